/* rtl/mpft_pkg.sv */
`timescale 1ns / 1ps

package mpft_pkg;

  localparam int MPFT_NUM_PIPES    = 12;
  localparam int MPFT_BUFFER_DEPTH = 1024;
  localparam int MPFT_ID_WIDTH     = 16;
  localparam int MPFT_MAX_REFS     = 255;

  localparam int OP_W        = 2;
  localparam int PIPE_ID_W   = 16;
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_OPEN  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } mpft_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_NOSLOT  = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4,
    ST_REFOVF  = 3'd5
  } mpft_status_e;

  // what the back end does with the byte store for one item
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } mpft_kind_e;

  typedef struct packed {
    mpft_kind_e   kind;
    mpft_status_e status;
  } mpft_cmd_t;

endpackage

/* rtl/mpft_front.sv */
`timescale 1ns / 1ps

module mpft_front import mpft_pkg::*; #(
  parameter int NUM_PIPES    = MPFT_NUM_PIPES,
  parameter int BUFFER_DEPTH = MPFT_BUFFER_DEPTH,
  parameter int ID_WIDTH     = MPFT_ID_WIDTH,
  parameter int MAX_REFS     = MPFT_MAX_REFS,
  parameter int ADDR_W       = $clog2(NUM_PIPES * BUFFER_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [PIPE_ID_W-1:0] pipe_id_i,
  output mpft_cmd_t            cmd_o,
  output logic [ADDR_W-1:0]    addr_o
);

  localparam int SLOT_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
  localparam int PTR_W  = $clog2(BUFFER_DEPTH);
  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
  localparam int REF_W  = $clog2(MAX_REFS + 1);

  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(BUFFER_DEPTH);
  localparam logic [REF_W-1:0]  REF_MAX  = REF_W'(MAX_REFS);
  localparam logic [ADDR_W-1:0] SLOT_SPAN = ADDR_W'(BUFFER_DEPTH);

  logic [NUM_PIPES-1:0] live_q, live_d;
  logic [ID_WIDTH-1:0]  ids_q  [NUM_PIPES];
  logic [ID_WIDTH-1:0]  ids_d  [NUM_PIPES];
  logic [REF_W-1:0]     refs_q [NUM_PIPES];
  logic [REF_W-1:0]     refs_d [NUM_PIPES];
  logic [PTR_W-1:0]     rptr_q [NUM_PIPES];
  logic [PTR_W-1:0]     rptr_d [NUM_PIPES];
  logic [PTR_W-1:0]     wptr_q [NUM_PIPES];
  logic [PTR_W-1:0]     wptr_d [NUM_PIPES];
  logic [FILL_W-1:0]    fill_q [NUM_PIPES];
  logic [FILL_W-1:0]    fill_d [NUM_PIPES];

  logic [31:0]          id_ext;
  logic [ID_WIDTH-1:0]  id;
  logic [NUM_PIPES-1:0] match;
  logic                 hit, free_any;
  logic [SLOT_W-1:0]    hit_idx, free_idx;
  logic [REF_W-1:0]     ref_dec;
  mpft_op_e             op;

  assign id_ext = 32'(pipe_id_i);
  assign id     = id_ext[ID_WIDTH-1:0];
  assign op     = mpft_op_e'(operation_i);

  // parallel slot match, lowest slot wins
  always_comb begin
    hit      = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = NUM_PIPES - 1; i >= 0; i--) begin
      match[i] = live_q[i] && (ids_q[i] == id);
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
      if (!live_q[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    live_d = live_q;
    ids_d  = ids_q;
    refs_d = refs_q;
    rptr_d = rptr_q;
    wptr_d = wptr_q;
    fill_d = fill_q;
    cmd_o  = '{kind: KIND_NONE, status: ST_OK};
    addr_o = '0;
    ref_dec = (refs_q[hit_idx] != '0) ? refs_q[hit_idx] - REF_W'(1) : '0;
    if (accept_i) begin
      unique case (op)
        OP_OPEN: begin
          if (hit) begin
            if (refs_q[hit_idx] >= REF_MAX) begin
              cmd_o.status = ST_REFOVF;
            end else begin
              refs_d[hit_idx] = refs_q[hit_idx] + REF_W'(1);
            end
          end else if (!free_any) begin
            cmd_o.status = ST_NOSLOT;
          end else begin
            live_d[free_idx] = 1'b1;
            ids_d[free_idx]  = id;
            rptr_d[free_idx] = '0;
            wptr_d[free_idx] = '0;
            fill_d[free_idx] = '0;
            refs_d[free_idx] = REF_W'(1);
          end
        end
        OP_CLOSE: begin
          if (!hit) begin
            cmd_o.status = ST_UNKNOWN;
          end else begin
            refs_d[hit_idx] = ref_dec;
            if (ref_dec == '0) begin
              live_d[hit_idx] = 1'b0;
            end
          end
        end
        OP_READ: begin
          if (!hit) begin
            cmd_o.status = ST_UNKNOWN;
          end else if (fill_q[hit_idx] == '0) begin
            cmd_o.status = ST_EMPTY;
          end else begin
            cmd_o.kind = KIND_READ;
            addr_o = ADDR_W'(hit_idx) * SLOT_SPAN + ADDR_W'(rptr_q[hit_idx]);
            rptr_d[hit_idx] = (rptr_q[hit_idx] == PTR_LAST) ? '0
                                                            : rptr_q[hit_idx] + PTR_W'(1);
            fill_d[hit_idx] = fill_q[hit_idx] - FILL_W'(1);
          end
        end
        OP_WRITE: begin
          if (!hit) begin
            cmd_o.status = ST_UNKNOWN;
          end else if (fill_q[hit_idx] >= FILL_MAX) begin
            cmd_o.status = ST_FULL;
          end else begin
            cmd_o.kind = KIND_WRITE;
            addr_o = ADDR_W'(hit_idx) * SLOT_SPAN + ADDR_W'(wptr_q[hit_idx]);
            wptr_d[hit_idx] = (wptr_q[hit_idx] == PTR_LAST) ? '0
                                                            : wptr_q[hit_idx] + PTR_W'(1);
            fill_d[hit_idx] = fill_q[hit_idx] + FILL_W'(1);
          end
        end
        default: begin
          cmd_o.status = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      for (int i = 0; i < NUM_PIPES; i++) begin
        ids_q[i]  <= '0;
        refs_q[i] <= '0;
        rptr_q[i] <= '0;
        wptr_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      live_q <= live_d;
      ids_q  <= ids_d;
      refs_q <= refs_d;
      rptr_q <= rptr_d;
      wptr_q <= wptr_d;
      fill_q <= fill_d;
    end
  end

  // checks: a live slot always holds a reference, no ring overfills
  logic [NUM_PIPES-1:0] live_no_ref, fill_over;
  always_comb begin
    for (int i = 0; i < NUM_PIPES; i++) begin
      live_no_ref[i] = live_q[i] && (refs_q[i] == '0);
      fill_over[i]   = fill_q[i] > FILL_MAX;
    end
  end

`ifndef SYNTHESIS
  a_live_has_ref: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_no_ref == '0) else $error("live slot with zero references");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_over == '0) else $error("fill level beyond ring depth");
`endif

endmodule

/* rtl/mpft_queue.sv */
`timescale 1ns / 1ps

module mpft_queue import mpft_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign data_o  = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_LAST) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_LAST) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o)) else $error("pop from empty queue");
`endif

endmodule

/* rtl/mpft_back.sv */
`timescale 1ns / 1ps

module mpft_back import mpft_pkg::*; #(
  parameter int MEM_DEPTH = MPFT_NUM_PIPES * MPFT_BUFFER_DEPTH,
  parameter int ADDR_W    = $clog2(MEM_DEPTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  mpft_cmd_t           cmd_i,
  input  logic [ADDR_W-1:0]   addr_i,
  input  logic [BYTE_W-1:0]   data_i,
  output logic                pop_o,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [BYTE_W-1:0]   read_data_o
);

  logic [BYTE_W-1:0] mem_q [MEM_DEPTH];
  logic [BYTE_W-1:0] rdata_q;
  logic              done_q, rd_en_q;
  mpft_status_e      status_q;

  // results cannot be held off, so the head item is taken in every cycle that it is valid
  assign pop_o       = valid_i;
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign read_data_o = rd_en_q ? rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (valid_i && (cmd_i.kind == KIND_WRITE)) begin
      mem_q[addr_i] <= data_i;
    end
    if (valid_i && (cmd_i.kind == KIND_READ)) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      rd_en_q  <= 1'b0;
      status_q <= ST_OK;
    end else begin
      done_q   <= valid_i;
      rd_en_q  <= valid_i && (cmd_i.kind == KIND_READ);
      status_q <= cmd_i.status;
    end
  end

`ifndef SYNTHESIS
  a_done_follows_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> done_o) else $error("popped item produced no result");
`endif

endmodule

/* rtl/multi_pipe_fifo_table_core.sv */
`timescale 1ns / 1ps
// The result strobe done_o is registered in the back end, behind the command queue.
// Throughput: one item per cycle; the slot table resolves each item combinationally
// and the single-port byte store serves one read or write per cycle.
// busy follows a full command queue, which the back end never lets fill since it
// pops the head item in every cycle that holds one; results are never stalled.
// Reset clears the slot table and the queue at once; the byte store has no reset.
module multi_pipe_fifo_table_core import mpft_pkg::*; #(
  parameter int NUM_PIPES    = MPFT_NUM_PIPES,
  parameter int BUFFER_DEPTH = MPFT_BUFFER_DEPTH,
  parameter int ID_WIDTH     = MPFT_ID_WIDTH,
  parameter int MAX_REFS     = MPFT_MAX_REFS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      operation_i,
  input  logic [PIPE_ID_W-1:0] pipe_id_i,
  input  logic [BYTE_W-1:0]    data_byte_i,
  output logic                 done_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [BYTE_W-1:0]    read_data_o
);

  localparam int MEM_DEPTH = NUM_PIPES * BUFFER_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int CMD_W     = $bits(mpft_cmd_t);
  localparam int Q_W       = CMD_W + ADDR_W + BYTE_W;

  logic              accept, q_full, q_valid, q_pop;
  mpft_cmd_t         f_cmd, b_cmd;
  logic [ADDR_W-1:0] f_addr, b_addr;
  logic [BYTE_W-1:0] b_data;
  logic [Q_W-1:0]    q_in, q_out;

  assign busy   = q_full;
  assign accept = start && !q_full;

  mpft_front #(
    .NUM_PIPES   (NUM_PIPES),
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .ID_WIDTH    (ID_WIDTH),
    .MAX_REFS    (MAX_REFS),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .operation_i(operation_i),
    .pipe_id_i  (pipe_id_i),
    .cmd_o      (f_cmd),
    .addr_o     (f_addr)
  );

  assign q_in = {f_cmd, f_addr, data_byte_i};

  mpft_queue #(
    .WIDTH(Q_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  assign {b_cmd, b_addr, b_data} = q_out;

  mpft_back #(
    .MEM_DEPTH(MEM_DEPTH),
    .ADDR_W   (ADDR_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .cmd_i      (b_cmd),
    .addr_i     (b_addr),
    .data_i     (b_data),
    .pop_o      (q_pop),
    .done_o     (done_o),
    .status_o   (status_o),
    .read_data_o(read_data_o)
  );

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mpft_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_ITEMS = 316;
  localparam int POOL_SIZE    = 18;

  typedef struct {
    mpft_status_e     status;
    logic [BYTE_W-1:0] rd;
  } pipe_result_t;

  // Keeps a copy of the slot table and rings, and predicts one result per item.
  class pipe_table_scoreboard;
    bit                   live [MPFT_NUM_PIPES];
    logic [PIPE_ID_W-1:0] ids [MPFT_NUM_PIPES];
    int unsigned          refs [MPFT_NUM_PIPES];
    int unsigned          rd_ptr [MPFT_NUM_PIPES];
    int unsigned          wr_ptr [MPFT_NUM_PIPES];
    int unsigned          fill [MPFT_NUM_PIPES];
    logic [BYTE_W-1:0]    ring [MPFT_NUM_PIPES][MPFT_BUFFER_DEPTH];
    pipe_result_t         expected_results [$];
    int                   errors;
    int                   items_seen;
    int                   results_seen;
    int                   status_count [6];

    function int find_live(logic [PIPE_ID_W-1:0] id);
      for (int i = 0; i < MPFT_NUM_PIPES; i++)
        if (live[i] && ids[i][MPFT_ID_WIDTH-1:0] == id[MPFT_ID_WIDTH-1:0]) return i;
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < MPFT_NUM_PIPES; i++)
        if (!live[i]) return i;
      return -1;
    endfunction

    function void note_item(mpft_op_e op, logic [PIPE_ID_W-1:0] id,
                            logic [BYTE_W-1:0] data);
      pipe_result_t r;
      int s;
      r.status = ST_OK;
      r.rd = '0;
      s = find_live(id);
      if (op == OP_OPEN) begin
        if (s >= 0) begin
          if (refs[s] >= MPFT_MAX_REFS) r.status = ST_REFOVF;
          else refs[s]++;
        end else begin
          s = find_free();
          if (s < 0) begin
            r.status = ST_NOSLOT;
          end else begin
            live[s] = 1'b1;
            ids[s] = id;
            rd_ptr[s] = 0;
            wr_ptr[s] = 0;
            fill[s] = 0;
            refs[s] = 1;
          end
        end
      end else if (s < 0) begin
        r.status = ST_UNKNOWN;
      end else if (op == OP_CLOSE) begin
        if (refs[s] > 0) refs[s]--;
        if (refs[s] == 0) live[s] = 1'b0;
      end else if (op == OP_READ) begin
        if (fill[s] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.rd = ring[s][rd_ptr[s]];
          rd_ptr[s] = (rd_ptr[s] + 1) % MPFT_BUFFER_DEPTH;
          fill[s]--;
        end
      end else begin
        if (fill[s] >= MPFT_BUFFER_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          ring[s][wr_ptr[s]] = data;
          wr_ptr[s] = (wr_ptr[s] + 1) % MPFT_BUFFER_DEPTH;
          fill[s]++;
        end
      end
      items_seen++;
      status_count[r.status]++;
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [BYTE_W-1:0] rd);
      pipe_result_t r;
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending: status %0d read_data %0h",
                 $time, status, rd);
        return;
      end
      r = expected_results.pop_front();
      if (status !== r.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d", $time, r.status, status);
      end
      if (rd !== r.rd) begin
        errors++;
        $display("%0t: read_data mismatch: expected %0h actual %0h", $time, r.rd, rd);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      operation = OP_OPEN;
  logic [PIPE_ID_W-1:0] pipe_id = '0;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 done_o;
  logic [STATUS_W-1:0]  status_o;
  logic [BYTE_W-1:0]    read_data_o;

  pipe_table_scoreboard sb = new();
  int                   cycle_count = 0;
  int                   burst_left = 0;
  logic [PIPE_ID_W-1:0] id_pool [POOL_SIZE];

  multi_pipe_fifo_table_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation),
    .pipe_id_i   (pipe_id),
    .data_byte_i (data_byte),
    .done_o      (done_o),
    .status_o    (status_o),
    .read_data_o (read_data_o)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(status_o, read_data_o);
  end

  // mostly back to back, some short gaps, a few long ones, and gapless bursts
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  // busy is registered, so its value at the falling edge holds at the next rising edge
  task automatic send_item(mpft_op_e op, logic [PIPE_ID_W-1:0] id,
                           logic [BYTE_W-1:0] data);
    int gap;
    logic was_busy;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    operation <= op;
    pipe_id   <= id;
    data_byte <= data;
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy !== 1'b0);
    sb.note_item(op, id, data);
  endtask

  function automatic logic [PIPE_ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return PIPE_ID_W'($urandom());
    return id_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic mpft_op_e pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return OP_OPEN;
    if (r < 30) return OP_CLOSE;
    if (r < 65) return OP_READ;
    return OP_WRITE;
  endfunction

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: unknown pipe on read, close and write, empty read, byte extremes, no free slot,
    // and a freed slot claimed again with cleared pointers
    send_item(OP_READ, 16'h0001, 8'h00);
    send_item(OP_CLOSE, 16'h0001, 8'h00);
    send_item(OP_WRITE, 16'h0001, 8'h5A);
    send_item(OP_OPEN, 16'h0000, 8'h00);
    send_item(OP_READ, 16'h0000, 8'h00);
    send_item(OP_WRITE, 16'h0000, 8'hFF);
    send_item(OP_WRITE, 16'h0000, 8'h00);
    send_item(OP_READ, 16'h0000, 8'h00);
    send_item(OP_READ, 16'h0000, 8'h00);
    send_item(OP_OPEN, 16'hFFFF, 8'h00);
    send_item(OP_WRITE, 16'hFFFF, 8'hA5);
    send_item(OP_READ, 16'hFFFF, 8'h00);
    for (int i = 0; i < 10; i++) send_item(OP_OPEN, PIPE_ID_W'(1) << i, 8'h00);
    send_item(OP_OPEN, 16'h1234, 8'h00);
    send_item(OP_WRITE, 16'h0000, 8'h77);
    send_item(OP_CLOSE, 16'h0000, 8'h00);
    send_item(OP_OPEN, 16'h0000, 8'h00);
    send_item(OP_READ, 16'h0000, 8'h00);

    // reference count up to its limit and past it
    for (int i = 0; i < MPFT_MAX_REFS + 1; i++) send_item(OP_OPEN, 16'h0002, 8'h00);

    // random: ids mostly from a pool a little larger than the table
    for (int i = 0; i < 10; i++) id_pool[i] = PIPE_ID_W'(1) << i;
    id_pool[10] = 16'h0000;
    id_pool[11] = 16'hFFFF;
    for (int i = 12; i < POOL_SIZE; i++) id_pool[i] = PIPE_ID_W'($urandom());
    for (int i = 0; i < RANDOM_ITEMS; i++) send_item(pick_op(), pick_id(), 8'($urandom()));

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Covered %0d items and %0d results: ok %0d, unknown %0d, no slot %0d,",
             sb.items_seen, sb.results_seen, sb.status_count[ST_OK],
             sb.status_count[ST_UNKNOWN], sb.status_count[ST_NOSLOT]);
    $display("  empty %0d, full %0d, reference overflow %0d; %0d mismatches",
             sb.status_count[ST_EMPTY], sb.status_count[ST_FULL],
             sb.status_count[ST_REFOVF], sb.errors);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/mpft_pkg.sv
rtl/mpft_front.sv
rtl/mpft_queue.sv
rtl/mpft_back.sv
rtl/multi_pipe_fifo_table_core.sv
test/testbench.sv
